// File: rtl/core/vnc_pkg.sv
package vnc_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register index, decoded from paddr[2]
  localparam logic REG_TARGET_NORM = 1'b0;

  typedef enum logic [1:0] {
    MODE_NORM  = 2'd0,
    MODE_LIMIT = 2'd1,
    MODE_CLAMP = 2'd2
  } mode_e;

  // per-lane control: rescale this component, and its sign
  typedef struct packed {
    logic scale;
    logic neg;
  } lane_ctl_t;

  typedef struct packed {
    logic lim;
    logic zl;
  } flag_t;

endpackage

// File: rtl/core/vnc_sqrt.sv
module vnc_sqrt #(
  parameter int unsigned DW     = vnc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*DW-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);
  import vnc_pkg::*;

  localparam int unsigned SW = 2 * DW;

  logic              v_q    [DW+1];
  logic [SW-1:0]     rem_q  [DW+1];
  logic [DW-1:0]     root_q [DW+1];
  logic [SIDE_W-1:0] side_q [DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < DW; k++) begin : g_stage
    localparam int unsigned BI = DW - 1 - k;
    logic [SW:0]   trial;
    logic [SW-1:0] rem_d;
    logic [DW-1:0] root_d;

    always_comb begin
      trial = ((SW+1)'(root_q[k]) << (BI + 1)) + ((SW+1)'(1) << (2 * BI));
      if ({1'b0, rem_q[k]} >= trial) begin
        rem_d  = rem_q[k] - trial[SW-1:0];
        root_d = root_q[k] | (DW'(1) << BI);
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[DW];
  assign root_o  = root_q[DW];
  assign side_o  = side_q[DW];

endmodule

// File: rtl/core/vnc_lane.sv
module vnc_lane #(
  parameter int unsigned DW = vnc_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DW-1:0]          len_i,
  input  logic [2*DW-2:0]        prod_i,
  input  vnc_pkg::lane_ctl_t     ctl_i,
  input  logic [DW-1:0]          direct_i,
  output logic [DW-1:0]          res_o
);
  import vnc_pkg::*;

  localparam int unsigned QW = DW - 1;
  localparam int unsigned PW = 2 * DW - 1;

  logic [PW-1:0] rem_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] len_q [QW+1];
  lane_ctl_t     ctl_q [QW+1];
  logic [DW-1:0] dir_q [QW+1];
  logic [DW-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= prod_i;
      quo_q[0] <= '0;
      len_q[0] <= len_i;
      ctl_q[0] <= ctl_i;
      dir_q[0] <= direct_i;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned BI = QW - 1 - k;
    logic [PW-1:0] dvs;
    logic [PW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      dvs = PW'(len_q[k]) << BI;
      if (rem_q[k] >= dvs) begin
        rem_d = rem_q[k] - dvs;
        quo_d = quo_q[k] | (QW'(1) << BI);
      end else begin
        rem_d = rem_q[k];
        quo_d = quo_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        quo_q[k+1] <= quo_d;
        len_q[k+1] <= len_q[k];
        ctl_q[k+1] <= ctl_q[k];
        dir_q[k+1] <= dir_q[k];
      end
    end
  end

  // quotient never exceeds the norm, so no saturation is reachable
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctl_q[QW].scale) begin
        res_q <= ctl_q[QW].neg ? ('0 - {1'b0, quo_q[QW]}) : {1'b0, quo_q[QW]};
      end else begin
        res_q <= dir_q[QW];
      end
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/vector_norm_clamp_core.sv
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+--------------------------------------
// in       | in_valid_i / in_ready_o          | mode_i, vec_x_i, vec_y_i, vec_z_i
// out      | out_valid_o / out_ready_i        | out_x_o, out_y_o, out_z_o,
//          |                                  | was_limited_o, zero_length_o
// cfg      | psel/penable/pwrite/pready (APB) | paddr, pwdata, prdata (target_norm)
//
// Takes one item per cycle while the output is not stalled; it chains a 24-stage square root
// and 23-stage divider lanes at the default width, one root or quotient bit per stage.
// Reset clears every valid bit and loads target_norm with 1.0.
// One pipeline-wide enable: when the output item is not taken the whole pipeline holds
// and in_ready_o drops; otherwise every stage advances.
module vector_norm_clamp_core #(
  parameter int unsigned DATA_WIDTH = vnc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = vnc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vnc_pkg::PADDR_W-1:0]  paddr,
  input  logic [vnc_pkg::PDATA_W-1:0]  pwdata,
  output logic [vnc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic signed [DATA_WIDTH-1:0] vec_x_i,
  input  logic signed [DATA_WIDTH-1:0] vec_y_i,
  input  logic signed [DATA_WIDTH-1:0] vec_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] out_x_o,
  output logic signed [DATA_WIDTH-1:0] out_y_o,
  output logic signed [DATA_WIDTH-1:0] out_z_o,
  output logic                         was_limited_o,
  output logic                         zero_length_o
);
  import vnc_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned NW = DW - 1;           // norm width
  localparam int unsigned SW = 2 * DW;           // sum of squares
  localparam int unsigned PW = 2 * DW - 1;       // component times norm
  localparam int unsigned LL = DW + 1;           // lane latency
  localparam int unsigned CW = $bits(lane_ctl_t);
  localparam int unsigned FW = $bits(flag_t);
  localparam int unsigned SIDE_W = 3 * PW + 3 * CW + 3 * DW + FW;
  localparam logic [NW-1:0] NORM_RST = NW'(64'd1 << FRAC_BITS);

  // ---------------------------------------------------------------- config
  logic [NW-1:0] norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= NORM_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_NORM)) begin
      norm_q <= pwdata[NW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_NORM) ? PDATA_W'(norm_q) : '0;

  // ---------------------------------------------------------------- stall
  logic en;
  logic fv_q [LL];

  // advance everything unless the output item is stuck
  assign en         = !fv_q[LL-1] || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- stage A: capture
  logic          a_v_q;
  logic [1:0]    a_mode_q;
  logic [DW-1:0] a_x_q, a_y_q, a_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q <= mode_i;
      a_x_q    <= vec_x_i;
      a_y_q    <= vec_y_i;
      a_z_q    <= vec_z_i;
    end
  end

  // ---------------------------------------------------------------- stage B: multiply
  logic [DW-1:0] ax, ay, az;

  assign ax = a_x_q[DW-1] ? ('0 - a_x_q) : a_x_q;
  assign ay = a_y_q[DW-1] ? ('0 - a_y_q) : a_y_q;
  assign az = a_z_q[DW-1] ? ('0 - a_z_q) : a_z_q;

  logic          b_v_q;
  logic [1:0]    b_mode_q;
  logic [DW-1:0] b_x_q, b_y_q, b_z_q;
  logic [SW-1:0] b_sqx_q, b_sqy_q, b_sqz_q;
  logic [SW-1:0] b_nn_q;
  logic [PW-1:0] b_px_q, b_py_q, b_pz_q;
  logic          b_xgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_mode_q <= a_mode_q;
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_z_q    <= a_z_q;
      b_sqx_q  <= SW'(ax) * SW'(ax);
      b_sqy_q  <= SW'(ay) * SW'(ay);
      b_sqz_q  <= SW'(az) * SW'(az);
      b_nn_q   <= SW'(norm_q) * SW'(norm_q);
      b_px_q   <= PW'(ax) * PW'(norm_q);
      b_py_q   <= PW'(ay) * PW'(norm_q);
      b_pz_q   <= PW'(az) * PW'(norm_q);
      b_xgt_q  <= ax > {1'b0, norm_q};
    end
  end

  // ---------------------------------------------------------------- stage C: decide
  logic [SW-1:0] sum;
  lane_ctl_t     cx, cy, cz;
  logic [DW-1:0] dx, dy, dz;
  flag_t         fl;
  mode_e         mode;

  assign sum  = b_sqx_q + b_sqy_q + b_sqz_q;
  assign mode = mode_e'(b_mode_q);

  always_comb begin
    cx = '{scale: 1'b0, neg: b_x_q[DW-1]};
    cy = '{scale: 1'b0, neg: b_y_q[DW-1]};
    cz = '{scale: 1'b0, neg: b_z_q[DW-1]};
    dx = '0;
    dy = '0;
    dz = '0;
    fl = '0;
    case (mode)
      MODE_NORM: begin
        // zero vector: zeros out, flag it
        cx.scale = (sum != '0);
        cy.scale = (sum != '0);
        cz.scale = (sum != '0);
        fl.zl    = (sum == '0);
      end
      MODE_LIMIT: begin
        cx.scale = (b_nn_q < sum);
        cy.scale = (b_nn_q < sum);
        cz.scale = (b_nn_q < sum);
        fl.lim   = (b_nn_q < sum);
        dx       = b_x_q;
        dy       = b_y_q;
        dz       = b_z_q;
      end
      MODE_CLAMP: begin
        fl.lim = b_xgt_q;
        if (b_xgt_q) begin
          dx = b_x_q[DW-1] ? ('0 - {1'b0, norm_q}) : {1'b0, norm_q};
        end else begin
          dx = b_x_q;
        end
      end
      default: begin
        fl = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- square root
  logic              sq_v;
  logic [DW-1:0]     len;
  logic [SIDE_W-1:0] side_in, side_out;
  logic [PW-1:0]     s_px, s_py, s_pz;
  lane_ctl_t         s_cx, s_cy, s_cz;
  logic [DW-1:0]     s_dx, s_dy, s_dz;
  flag_t             s_fl;

  assign side_in = {b_px_q, b_py_q, b_pz_q, cx, cy, cz, dx, dy, dz, fl};
  assign {s_px, s_py, s_pz, s_cx, s_cy, s_cz, s_dx, s_dy, s_dz, s_fl} = side_out;

  vnc_sqrt #(
    .DW     (DW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .rad_i   (sum),
    .side_i  (side_in),
    .valid_o (sq_v),
    .root_o  (len),
    .side_o  (side_out)
  );

  // ---------------------------------------------------------------- lanes
  logic [DW-1:0] rx, ry, rz;

  vnc_lane #(.DW(DW)) u_lane_x (
    .clk_i (clk_i), .en_i (en), .len_i (len), .prod_i (s_px),
    .ctl_i (s_cx), .direct_i (s_dx), .res_o (rx)
  );

  vnc_lane #(.DW(DW)) u_lane_y (
    .clk_i (clk_i), .en_i (en), .len_i (len), .prod_i (s_py),
    .ctl_i (s_cy), .direct_i (s_dy), .res_o (ry)
  );

  vnc_lane #(.DW(DW)) u_lane_z (
    .clk_i (clk_i), .en_i (en), .len_i (len), .prod_i (s_pz),
    .ctl_i (s_cz), .direct_i (s_dz), .res_o (rz)
  );

  // ---------------------------------------------------------------- merge
  // delay valid and flags alongside the lanes, then present with lane results
  flag_t f_q [LL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q[0] <= 1'b0;
    end else if (en) begin
      fv_q[0] <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q[0] <= s_fl;
    end
  end

  for (genvar k = 1; k < LL; k++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[k] <= 1'b0;
      end else if (en) begin
        fv_q[k] <= fv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        f_q[k] <= f_q[k-1];
      end
    end
  end

  assign out_valid_o   = fv_q[LL-1];
  assign out_x_o       = rx;
  assign out_y_o       = ry;
  assign out_z_o       = rz;
  assign was_limited_o = f_q[LL-1].lim;
  assign zero_length_o = f_q[LL-1].zl;

  // ---------------------------------------------------------------- checks
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_limited_o && zero_length_o))
    else $error("both result flags set");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_length_o) |-> (out_x_o == '0 && out_y_o == '0 && out_z_o == '0))
    else $error("zero-length item with nonzero output");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule
